### hdl/block_buffer_cache_lru_defines.svh
// Assertion macros for the buffer cache tag directory.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`ifndef ASSERT_OFF
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define BBC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define BBC_ASSERT(lbl, prop, msg)
`define BBC_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

### hdl/bbc_pkg.sv
// Types and codes shared by the buffer cache tag directory.
// No dependencies.
package bbc_pkg;

  localparam int unsigned TagW = 32;

  typedef enum logic {
    FUNC_READ = 1'b0,
    FUNC_MARK = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    KIND_WB   = 2'd0,
    KIND_HIT  = 2'd1,
    KIND_FILL = 2'd2,
    KIND_MARK = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MARK   = 7'b0000010,
    S_LOOKUP = 7'b0000100,
    S_HIT    = 7'b0001000,
    S_VICTIM = 7'b0010000,
    S_WB     = 7'b0100000,
    S_FILL   = 7'b1000000
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [7:0]  dev;
    logic [23:0] block;
    logic [3:0]  buffer;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  buf_index;
    logic [7:0]  out_dev;
    logic [23:0] out_block;
    logic        last;
  } rsp_t;

endpackage

### hdl/bbc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module bbc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bbc_lru.sv
// LRU order of the buffers, position 0 least recent.
// Reads the entry at one position and moves it to the recent end on request.
module bbc_lru #(
  parameter int unsigned NumBuf = 16,
  localparam int unsigned IdxW = $clog2(NumBuf)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            move_i,
  input  logic [IdxW-1:0] pos_i,
  output logic [IdxW-1:0] idx_o
);

  logic [IdxW-1:0] order_q [NumBuf];
  logic [IdxW-1:0] order_d [NumBuf];

  assign idx_o = order_q[pos_i];

  for (genvar g = 0; g < NumBuf; g++) begin : g_slot
    if (g == NumBuf - 1) begin : g_tail
      assign order_d[g] = move_i ? idx_o : order_q[g];
    end else begin : g_body
      assign order_d[g] = (move_i && IdxW'(g) >= pos_i) ? order_q[g+1] : order_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumBuf; i++) begin
        order_q[i] <= IdxW'(i);
      end
    end else if (move_i) begin
      order_q <= order_d;
    end
  end

endmodule

### hdl/block_buffer_cache_lru.sv
// Tag directory of a fully associative disk block cache with LRU replacement.
// Uses bbc_pkg, bbc_ram, bbc_lru and block_buffer_cache_lru_defines.svh.
//
// Input channel (in_valid_i, in_stall_o, in_i) takes one request item at a time:
// a read by device and block, or a mark of one buffer as delayed-write.
// Output channel (out_valid_o, out_stall_i, out_o) returns the result items of
// the request in order: one hit, or zero or more writebacks followed by one
// fill, or one mark ack. Only the final item of a request has last set.
// The block is busy from acceptance until its final item is in the output
// register; in_stall_o is high meanwhile.
// Steps: a mark item is registered straight from S_MARK; a read walks the LRU order
// in S_LOOKUP with one tag compare per cycle through the tag RAM read port,
// then a hit is registered from S_HIT, while a miss passes S_VICTIM and a
// writeback from S_WB per dirty victim before the fill from S_FILL. The next item is
// accepted in the cycle after the final item is registered.
// Each result item waits in the output register while the receiver
// stalls, which holds the sequencer.
// Reset clears valid and dirty bits and sets the LRU order to 0 .. N-1.
// Tags hold no value until a fill writes them.
`include "block_buffer_cache_lru_defines.svh"
module block_buffer_cache_lru #(
  parameter int unsigned NUM_BUFFERS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bbc_pkg::req_t in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bbc_pkg::rsp_t out_o
);

  import bbc_pkg::*;

  localparam int unsigned IdxW = $clog2(NUM_BUFFERS);
  localparam int unsigned PosW = IdxW + 1;
  localparam logic [PosW-1:0] NumPos = PosW'(NUM_BUFFERS);
  localparam logic [IdxW-1:0] LastPos = IdxW'(NUM_BUFFERS - 1);

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [PosW-1:0]        p_q, p_d;
  logic                   cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]        cmp_pos_q, cmp_pos_d;
  logic [IdxW-1:0]        cmp_buf_q, cmp_buf_d;
  logic [IdxW-1:0]        hit_pos_q, hit_pos_d;
  logic [NUM_BUFFERS-1:0] valid_q, valid_d;
  logic [NUM_BUFFERS-1:0] dirty_q, dirty_d;
  logic                   out_vld_q;
  rsp_t                   out_q;

  logic            slot_free;
  logic            emit;
  rsp_t            emit_rsp;
  logic            lru_move;
  logic [IdxW-1:0] lru_pos;
  logic [IdxW-1:0] lru_idx;
  logic            ram_we;
  logic [IdxW-1:0] ram_raddr;
  logic [TagW-1:0] ram_rdata;
  logic [IdxW-1:0] mark_idx;
  logic            mark_ok;
  logic            tag_hit;

  bbc_lru #(
    .NumBuf(NUM_BUFFERS)
  ) u_lru (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .move_i(lru_move),
    .pos_i (lru_pos),
    .idx_o (lru_idx)
  );

  bbc_ram #(
    .Width(TagW),
    .Depth(NUM_BUFFERS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(lru_idx),
    .wdata_i({req_q.dev, req_q.block}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign slot_free = !out_vld_q || !out_stall_i;
  assign mark_idx  = IdxW'(req_q.buffer);
  assign mark_ok   = ({2'b00, req_q.buffer} < 6'(NUM_BUFFERS)) && valid_q[mark_idx];
  assign tag_hit   = cmp_vld_q && valid_q[cmp_buf_q] &&
                     (ram_rdata == {req_q.dev, req_q.block});

  always_comb begin
    lru_pos = '0;
    if (state_q == S_LOOKUP) begin
      lru_pos = p_q[IdxW-1:0];
    end else if (state_q == S_HIT) begin
      lru_pos = hit_pos_q;
    end
  end

  always_comb begin
    ram_raddr = lru_idx;
    if (state_q == S_IDLE) begin
      ram_raddr = IdxW'(in_i.buffer);
    end else if (state_q == S_MARK) begin
      ram_raddr = mark_idx;
    end
  end

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    p_d       = p_q;
    cmp_vld_d = 1'b0;
    cmp_pos_d = cmp_pos_q;
    cmp_buf_d = cmp_buf_q;
    hit_pos_d = hit_pos_q;
    valid_d   = valid_q;
    dirty_d   = dirty_q;
    lru_move  = 1'b0;
    ram_we    = 1'b0;
    emit      = 1'b0;
    emit_rsp  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_i;
          p_d     = '0;
          state_d = (in_i.func == FUNC_MARK) ? S_MARK : S_LOOKUP;
        end
      end
      S_MARK: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_rsp.kind      = KIND_MARK;
          emit_rsp.buf_index = req_q.buffer;
          emit_rsp.last      = 1'b1;
          if (mark_ok) begin
            dirty_d[mark_idx]  = 1'b1;
            emit_rsp.out_dev   = ram_rdata[TagW-1 -: 8];
            emit_rsp.out_block = ram_rdata[23:0];
          end
          state_d = S_IDLE;
        end
      end
      S_LOOKUP: begin
        if (p_q < NumPos) begin
          cmp_vld_d = 1'b1;
          cmp_pos_d = p_q[IdxW-1:0];
          cmp_buf_d = lru_idx;
          p_d       = p_q + 1'b1;
        end
        if (tag_hit) begin
          hit_pos_d = cmp_pos_q;
          cmp_vld_d = 1'b0;
          state_d   = S_HIT;
        end else if (cmp_vld_q && cmp_pos_q == LastPos) begin
          state_d = S_VICTIM;
        end
      end
      S_HIT: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_rsp.kind      = KIND_HIT;
          emit_rsp.buf_index = 4'(lru_idx);
          emit_rsp.out_dev   = req_q.dev;
          emit_rsp.out_block = req_q.block;
          emit_rsp.last      = 1'b1;
          lru_move           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      S_VICTIM: begin
        state_d = dirty_q[lru_idx] ? S_WB : S_FILL;
      end
      S_WB: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_rsp.kind      = KIND_WB;
          emit_rsp.buf_index = 4'(lru_idx);
          emit_rsp.out_dev   = ram_rdata[TagW-1 -: 8];
          emit_rsp.out_block = ram_rdata[23:0];
          dirty_d[lru_idx]   = 1'b0;
          lru_move           = 1'b1;
          state_d            = S_VICTIM;
        end
      end
      S_FILL: begin
        if (slot_free) begin
          emit               = 1'b1;
          emit_rsp.kind      = KIND_FILL;
          emit_rsp.buf_index = 4'(lru_idx);
          emit_rsp.out_dev   = req_q.dev;
          emit_rsp.out_block = req_q.block;
          emit_rsp.last      = 1'b1;
          ram_we             = 1'b1;
          valid_d[lru_idx]   = 1'b1;
          dirty_d[lru_idx]   = 1'b0;
          lru_move           = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      p_q       <= '0;
      cmp_vld_q <= 1'b0;
      valid_q   <= '0;
      dirty_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      p_q       <= p_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
      dirty_q   <= dirty_d;
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cmp_pos_q <= cmp_pos_d;
    cmp_buf_q <= cmp_buf_d;
    hit_pos_q <= hit_pos_d;
    if (emit) begin
      out_q <= emit_rsp;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `BBC_ASSERT(a_partial_is_wb, out_valid_o && !out_o.last |-> out_o.kind == KIND_WB, "non-final item is not a writeback")
  `BBC_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> state_q != S_IDLE, "accepted item left sequencer idle")
  `BBC_ASSERT_NEVER(a_dirty_valid, |(dirty_q & ~valid_q), "dirty buffer without valid tag")
  `BBC_ASSERT_NEVER(a_pos_range, p_q > NumPos, "lookup position beyond buffer count")

endmodule

### verif/tb_block_buffer_cache_lru.sv
// Testbench for the buffer cache tag directory: directed and random requests with
// handshake idling, checked item by item against a behavioral directory model.
// Depends on bbc_pkg and block_buffer_cache_lru.
module tb_block_buffer_cache_lru;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int unsigned NumBuf      = 16;
  localparam int unsigned PoolSize    = 20;
  localparam int unsigned DrainCycles = 48;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  req_t in_i        = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_o;

  block_buffer_cache_lru #(
    .NUM_BUFFERS(NumBuf)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  logic [7:0]  dir_dev   [NumBuf];
  logic [23:0] dir_blk   [NumBuf];
  logic        dir_valid [NumBuf];
  logic        dir_dirty [NumBuf];
  int unsigned lru_q[$];
  rsp_t        due_rsp_q[$];
  logic [31:0] tag_pool  [PoolSize];

  int unsigned send_idle_pct = 0;
  int unsigned rsp_idle_pct  = 0;
  int unsigned rsp_hold_left = 0;
  int unsigned mismatches    = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic rsp_t make_rsp(kind_e k, int unsigned idx, logic [7:0] d,
                                    logic [23:0] b, logic l);
    rsp_t r;
    r.kind      = k;
    r.buf_index = idx[3:0];
    r.out_dev   = d;
    r.out_block = b;
    r.last      = l;
    return r;
  endfunction

  function automatic void move_recent(int unsigned pos);
    int unsigned b;
    b = lru_q[pos];
    lru_q.delete(pos);
    lru_q.push_back(b);
  endfunction

  function automatic void predict_directory(req_t r);
    int unsigned b;
    int unsigned n;
    if (r.func == FUNC_MARK) begin
      b = r.buffer;
      if (dir_valid[b]) begin
        dir_dirty[b] = 1'b1;
        due_rsp_q.push_back(make_rsp(KIND_MARK, b, dir_dev[b], dir_blk[b], 1'b1));
      end else begin
        due_rsp_q.push_back(make_rsp(KIND_MARK, b, 8'h00, 24'h000000, 1'b1));
      end
      return;
    end
    for (int unsigned p = 0; p < NumBuf; p++) begin
      b = lru_q[p];
      if (dir_valid[b] && dir_dev[b] == r.dev && dir_blk[b] == r.block) begin
        move_recent(p);
        due_rsp_q.push_back(make_rsp(KIND_HIT, b, r.dev, r.block, 1'b1));
        return;
      end
    end
    n = 0;
    while (dir_dirty[lru_q[0]] && n < NumBuf) begin
      b = lru_q[0];
      due_rsp_q.push_back(make_rsp(KIND_WB, b, dir_dev[b], dir_blk[b], 1'b0));
      dir_dirty[b] = 1'b0;
      move_recent(0);
      n++;
    end
    b = lru_q[0];
    dir_dev[b]   = r.dev;
    dir_blk[b]   = r.block;
    dir_valid[b] = 1'b1;
    dir_dirty[b] = 1'b0;
    move_recent(0);
    due_rsp_q.push_back(make_rsp(KIND_FILL, b, r.dev, r.block, 1'b1));
  endfunction

  function automatic req_t read_req(logic [7:0] d, logic [23:0] b);
    req_t r;
    r.func   = FUNC_READ;
    r.dev    = d;
    r.block  = b;
    r.buffer = 4'($urandom_range(NumBuf - 1));
    return r;
  endfunction

  function automatic req_t mark_req(int unsigned idx);
    req_t r;
    logic [31:0] junk;
    junk     = $urandom();
    r.func   = FUNC_MARK;
    r.dev    = junk[31:24];
    r.block  = junk[23:0];
    r.buffer = idx[3:0];
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned sel;
    logic [31:0] tag;
    sel = $urandom_range(99);
    if (sel < 20) begin
      return mark_req($urandom_range(NumBuf - 1));
    end
    if (sel < 30) begin
      tag = $urandom();
    end else begin
      tag = tag_pool[$urandom_range(PoolSize - 1)];
    end
    return read_req(tag[31:24], tag[23:0]);
  endfunction

  task automatic send_req(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_directory(r);
  endtask

  // Receiver: long hold when requested, otherwise random stalls.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rsp_hold_left != 0) begin
        out_stall_i <= 1'b1;
        rsp_hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < rsp_idle_pct);
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : check_rsp
    rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_rsp_q.size() == 0) begin
        $error("unexpected result item: kind %0d buffer %0d", out_o.kind, out_o.buf_index);
        mismatches++;
      end else begin
        exp_rsp = due_rsp_q.pop_front();
        check_field("kind", exp_rsp.kind, out_o.kind);
        check_field("buf_index", exp_rsp.buf_index, out_o.buf_index);
        check_field("out_dev", exp_rsp.out_dev, out_o.out_dev);
        check_field("out_block", exp_rsp.out_block, out_o.out_block);
        check_field("last", exp_rsp.last, out_o.last);
      end
    end
  end

  task automatic test_mark_unfilled();
    send_req(mark_req(0));
    send_req(mark_req(NumBuf - 1));
    send_req(mark_req(10));
  endtask

  task automatic test_fill_and_hit();
    send_req(read_req(8'h00, 24'h000000));
    send_req(read_req(8'hFF, 24'hFFFFFF));
    send_req(read_req(8'h00, 24'hFFFFFF));
    send_req(read_req(8'hFF, 24'h000000));
    send_req(read_req(8'h5A, 24'hA5A5A5));
    send_req(read_req(8'hFF, 24'hFFFFFF));
    send_req(read_req(8'h00, 24'h000000));
    send_req(read_req(8'h5A, 24'hA5A5A5));
  endtask

  task automatic test_mark_filled();
    send_req(mark_req(0));
    send_req(mark_req(2));
    send_req(mark_req(4));
    send_req(mark_req(0));
    send_req(read_req(8'h00, 24'h000000));
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned s_pct,
                                     input int unsigned r_pct);
    send_idle_pct = s_pct;
    rsp_idle_pct  = r_pct;
    repeat (count) send_req(random_req());
  endtask

  // Hold the receiver at the start, then fill, dirty and evict every buffer.
  task automatic test_full_writeback_burst();
    send_idle_pct = 0;
    rsp_idle_pct  = 0;
    rsp_hold_left = 300;
    for (int unsigned i = 0; i < NumBuf; i++) begin
      send_req(read_req(8'hC3, 24'hE00000 | 24'(i)));
    end
    for (int unsigned i = 0; i < NumBuf; i++) begin
      send_req(mark_req(i));
    end
    send_req(read_req(8'h3C, 24'h0F0F0F));
  endtask

  initial begin
    for (int unsigned i = 0; i < NumBuf; i++) begin
      dir_valid[i] = 1'b0;
      dir_dirty[i] = 1'b0;
      lru_q.push_back(i);
    end
    for (int unsigned i = 0; i < PoolSize; i++) begin
      tag_pool[i] = $urandom();
    end
    tag_pool[0] = 32'h00000000;
    tag_pool[1] = 32'hFFFFFFFF;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mark_unfilled();
    test_fill_and_hit();
    test_mark_filled();
    test_random_traffic(95, 26, 52);
    test_random_traffic(95, 52, 26);
    test_random_traffic(95, 0, 0);
    test_full_writeback_burst();
    in_valid_i <= 1'b0;

    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
